[hw/rtl/sclp_pkg.sv]
// ----------------------------------------------------------------------------
// sclp_pkg
// Shared types and codes for the serial command line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sclp_pkg;

  // result kinds
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_TIMER   = 2'd1;
  localparam logic [1:0] KIND_SAMPLES = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [3:0] {
    PH_START, PH_WS1, PH_SIGN1, PH_DIG1, PH_WS2, PH_SIGN2, PH_DIG2, PH_DONE, PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    LET_NONE, LET_P, LET_M
  } letter_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
  } sclp_result_t;

endpackage : sclp_pkg

`default_nettype wire

[hw/rtl/serial_command_line_parser_core.sv]
// ----------------------------------------------------------------------------
// serial_command_line_parser_core
// Parses newline-terminated command lines byte by byte into timer and
// sample-count commands.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  input    in   in_valid/in_stall   rx_byte
//  output   out  out_valid/out_stall command_kind, first_value, second_value
//
//  One byte per cycle while no newline waits: a byte sits in the input register,
//  then updates the line state; a newline loads the result register.
//  An accepted newline passes through the input register into the result register.
//  A newline waits in the input register only while the result register is
//  full and stalled; other bytes keep flowing.
//  Synchronous reset clears the line state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_line_parser_core #(
  parameter int LINE_CAPACITY = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              command_kind,
  output logic signed [31:0]      first_value,
  output logic signed [31:0]      second_value
);
  import sclp_pkg::*;

  logic         byte_valid;
  logic [7:0]   byte_q;
  logic         is_newline;
  logic         advance;
  logic         in_take;
  sclp_result_t line_result;

  assign is_newline = (byte_q == CHAR_NEWLINE);
  assign advance    = byte_valid && (!is_newline || !out_valid || !out_stall);
  assign in_stall   = byte_valid && !advance;
  assign in_take    = in_valid && !in_stall;

  sclp_parser #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (byte_q),
    .result  (line_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_take) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_q <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_newline) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_newline) begin
      command_kind <= line_result.kind;
      first_value  <= $signed(line_result.first);
      second_value <= $signed(line_result.second);
    end
  end

endmodule : serial_command_line_parser_core

`default_nettype wire

[hw/rtl/sclp_parser.sv]
// ----------------------------------------------------------------------------
// sclp_parser
// Per-line parse state: consumes one byte per step and presents the
// result for the line held so far.
// ----------------------------------------------------------------------------
`default_nettype none

module sclp_parser #(
  parameter int LINE_CAPACITY = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            rx_byte,
  output sclp_pkg::sclp_result_t     result
);
  import sclp_pkg::*;

  localparam int CNT_W = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_CAPACITY - 1);
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  function automatic logic [31:0] add_digit(input logic [31:0] mag, input logic [3:0] d);
    logic [35:0] m;
    m = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {32'b0, d};
    if (m > {4'b0, MAG_LIMIT}) begin
      return MAG_LIMIT;
    end
    return m[31:0];
  endfunction

  function automatic logic [31:0] finish_value(input logic [31:0] mag, input logic neg);
    if (neg) begin
      return 32'd0 - mag;
    end
    return mag[31] ? 32'h7FFF_FFFF : mag;
  endfunction

  phase_t          phase, phase_next;
  letter_t         letter, letter_next;
  logic [CNT_W-1:0] char_count, char_count_next;
  logic [31:0]     first_accum, first_accum_next;
  logic [31:0]     second_accum, second_accum_next;
  logic            first_negative, first_negative_next;
  logic            second_negative, second_negative_next;
  logic            line_ended, line_ended_next;

  logic       is_space, is_digit, is_sign;
  logic [3:0] digit;

  assign is_space = (rx_byte == 8'h20) || (rx_byte >= 8'h09 && rx_byte <= 8'h0D);
  assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
  assign is_sign  = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
  assign digit    = rx_byte[3:0];

  // next state
  always_comb begin
    phase_next           = phase;
    letter_next          = letter;
    char_count_next      = char_count;
    first_accum_next     = first_accum;
    second_accum_next    = second_accum;
    first_negative_next  = first_negative;
    second_negative_next = second_negative;
    line_ended_next      = line_ended;
    if (step) begin
      if (rx_byte == CHAR_NEWLINE) begin
        phase_next           = PH_START;
        letter_next          = LET_NONE;
        char_count_next      = '0;
        first_accum_next     = '0;
        second_accum_next    = '0;
        first_negative_next  = 1'b0;
        second_negative_next = 1'b0;
        line_ended_next      = 1'b0;
      end else if (char_count < CNT_LAST) begin
        char_count_next = char_count + CNT_W'(1);
        if (!line_ended) begin
          if (rx_byte == CHAR_NUL) begin
            line_ended_next = 1'b1;
          end else begin
            unique case (phase)
              PH_START: begin
                if (rx_byte == CHAR_P) begin
                  letter_next = LET_P;
                  phase_next  = PH_WS1;
                end else if (rx_byte == CHAR_M) begin
                  letter_next = LET_M;
                  phase_next  = PH_WS1;
                end else begin
                  phase_next = PH_FAIL;
                end
              end
              PH_WS1: begin
                if (is_space) begin
                  phase_next = PH_WS1;
                end else if (is_sign) begin
                  first_negative_next = (rx_byte == CHAR_MINUS);
                  phase_next          = PH_SIGN1;
                end else if (is_digit) begin
                  first_accum_next = add_digit(first_accum, digit);
                  phase_next       = PH_DIG1;
                end else begin
                  phase_next = PH_FAIL;
                end
              end
              PH_SIGN1: begin
                if (is_digit) begin
                  first_accum_next = add_digit(first_accum, digit);
                  phase_next       = PH_DIG1;
                end else begin
                  phase_next = PH_FAIL;
                end
              end
              PH_DIG1: begin
                if (is_digit) begin
                  first_accum_next = add_digit(first_accum, digit);
                end else if (letter == LET_M) begin
                  phase_next = PH_DONE;
                end else if (rx_byte == CHAR_COMMA) begin
                  phase_next = PH_WS2;
                end else begin
                  phase_next = PH_FAIL;
                end
              end
              PH_WS2: begin
                if (is_space) begin
                  phase_next = PH_WS2;
                end else if (is_sign) begin
                  second_negative_next = (rx_byte == CHAR_MINUS);
                  phase_next           = PH_SIGN2;
                end else if (is_digit) begin
                  second_accum_next = add_digit(second_accum, digit);
                  phase_next        = PH_DIG2;
                end else begin
                  phase_next = PH_FAIL;
                end
              end
              PH_SIGN2: begin
                if (is_digit) begin
                  second_accum_next = add_digit(second_accum, digit);
                  phase_next        = PH_DIG2;
                end else begin
                  phase_next = PH_FAIL;
                end
              end
              PH_DIG2: begin
                if (is_digit) begin
                  second_accum_next = add_digit(second_accum, digit);
                end else begin
                  phase_next = PH_DONE;
                end
              end
              default: begin
                phase_next = phase;
              end
            endcase
          end
        end
      end
    end
  end

  // line result as of the current state
  always_comb begin
    result = '{kind: KIND_INVALID, first: 32'd0, second: 32'd0};
    if (letter == LET_P && (phase == PH_DIG2 || phase == PH_DONE)) begin
      result.kind   = KIND_TIMER;
      result.first  = finish_value(first_accum, first_negative);
      result.second = finish_value(second_accum, second_negative);
    end else if (letter == LET_M && (phase == PH_DIG1 || phase == PH_DONE)) begin
      result.kind  = KIND_SAMPLES;
      result.first = finish_value(first_accum, first_negative);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      letter          <= LET_NONE;
      char_count      <= '0;
      first_accum     <= '0;
      second_accum    <= '0;
      first_negative  <= 1'b0;
      second_negative <= 1'b0;
      line_ended      <= 1'b0;
    end else begin
      phase           <= phase_next;
      letter          <= letter_next;
      char_count      <= char_count_next;
      first_accum     <= first_accum_next;
      second_accum    <= second_accum_next;
      first_negative  <= first_negative_next;
      second_negative <= second_negative_next;
      line_ended      <= line_ended_next;
    end
  end

endmodule : sclp_parser

`default_nettype wire

[hw/rtl/sclp_checker.sv]
// ----------------------------------------------------------------------------
// sclp_checker
// Port-level checks on the parser core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sclp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         command_kind,
  input wire logic signed [31:0] first_value,
  input wire logic signed [31:0] second_value
);
  import sclp_pkg::*;

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command_kind)
      && $stable(first_value) && $stable(second_value))
    else $error("stalled result beat changed");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command_kind == KIND_INVALID || command_kind == KIND_TIMER
      || command_kind == KIND_SAMPLES)
    else $error("unknown command kind");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_kind == KIND_INVALID |-> first_value == 32'sd0
      && second_value == 32'sd0)
    else $error("invalid line carries values");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_kind != KIND_TIMER |-> second_value == 32'sd0)
    else $error("second value set outside timer command");

endmodule : sclp_checker

bind serial_command_line_parser_core sclp_checker u_sclp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .command_kind (command_kind),
  .first_value  (first_value),
  .second_value (second_value)
);

`default_nettype wire
